// File: sv/tbfc_pkg.sv
// tbfc_pkg: shared constants and types
// for the thermal bilinear false color block; no dependencies
package tbfc_pkg;

  localparam int IN_WIDTH_DEF   = 32;
  localparam int IN_HEIGHT_DEF  = 24;
  localparam int OUT_WIDTH_DEF  = 240;
  localparam int OUT_HEIGHT_DEF = 280;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  // -20 degrees in 1/64 units and the span up to 300 degrees
  localparam int TEMP_OFFSET = 1280;
  localparam int COLOR_SPAN  = 20480;

  typedef struct packed {
    logic        action;
    logic [9:0]  sample_index;
    logic [15:0] sample_temp;
    logic [7:0]  screen_x;
    logic [8:0]  screen_y;
  } tbfc_in_t;

  typedef struct packed {
    logic [15:0] interp_temp;
    logic [7:0]  red;
    logic [6:0]  green;
    logic [7:0]  blue;
  } tbfc_out_t;

endpackage

// File: sv/tbfc_if.sv
// tbfc_if: valid/ready channel carrying one payload word
// depends on nothing; payload type given as a type parameter
interface tbfc_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/tbfc_frame_mem.sv
// tbfc_frame_mem: four banks of frame memory split on column/row parity
// depends on tbfc_pkg; one write port, one registered read per bank
module tbfc_frame_mem
  import tbfc_pkg::*;
#(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int IN_HEIGHT = IN_HEIGHT_DEF,
  localparam int CW = $clog2(IN_WIDTH),
  localparam int RW = $clog2(IN_HEIGHT),
  localparam int BCW = (CW > 1) ? CW - 1 : 1,
  localparam int BRW = (RW > 1) ? RW - 1 : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [CW-1:0]     wr_col,
  input  logic [RW-1:0]     wr_row,
  input  logic [15:0]       wr_data,
  input  logic              rd_en,
  input  logic [CW-1:0]     col_a,
  input  logic [CW-1:0]     col_b,
  input  logic [RW-1:0]     row_a,
  input  logic [RW-1:0]     row_b,
  output logic [3:0][15:0]  rd_data
);
  // bank b = {row parity, col parity}; the neighbours x1,x2 differ in parity
  // unless clamped, so each bank is read at most once per render
  localparam int BDEPTH = (1 << BCW) * (1 << BRW);
  logic [15:0] bank0 [BDEPTH];
  logic [15:0] bank1 [BDEPTH];
  logic [15:0] bank2 [BDEPTH];
  logic [15:0] bank3 [BDEPTH];

  function automatic logic [BCW-1:0] hc(input logic [CW-1:0] c);
    hc = BCW'(c >> 1);
  endfunction
  function automatic logic [BRW-1:0] hr(input logic [RW-1:0] r);
    hr = BRW'(r >> 1);
  endfunction

  logic [BCW-1:0] c_even, c_odd;
  logic [BRW-1:0] r_even, r_odd;
  logic [1:0]     wbank;
  logic [BRW+BCW-1:0] waddr;

  always_comb begin
    c_even = col_a[0] ? hc(col_b) : hc(col_a);
    c_odd  = col_a[0] ? hc(col_a) : hc(col_b);
    r_even = row_a[0] ? hr(row_b) : hr(row_a);
    r_odd  = row_a[0] ? hr(row_a) : hr(row_b);
    wbank  = {wr_row[0], wr_col[0]};
    waddr  = {hr(wr_row), hc(wr_col)};
  end

  always_ff @(posedge clk) begin
    if (wr_en && wbank == 2'd0) bank0[waddr] <= wr_data;
    if (wr_en && wbank == 2'd1) bank1[waddr] <= wr_data;
    if (wr_en && wbank == 2'd2) bank2[waddr] <= wr_data;
    if (wr_en && wbank == 2'd3) bank3[waddr] <= wr_data;
    if (rd_en) begin
      rd_data[0] <= bank0[{r_even, c_even}];
      rd_data[1] <= bank1[{r_even, c_odd}];
      rd_data[2] <= bank2[{r_odd, c_even}];
      rd_data[3] <= bank3[{r_odd, c_odd}];
    end
  end
endmodule

// File: sv/tbfc_interp.sv
// tbfc_interp: pipelined bilinear blend, floor divide and color map
// depends on tbfc_pkg; stalls as one unit on en
module tbfc_interp
  import tbfc_pkg::*;
#(
  parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = OUT_HEIGHT_DEF,
  localparam int WXW = $clog2(OUT_WIDTH + 1),
  localparam int WYW = $clog2(OUT_HEIGHT + 1),
  localparam int DEN = OUT_WIDTH * OUT_HEIGHT,
  localparam int DW  = $clog2(DEN + 1)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [15:0]       q11,
  input  logic [15:0]       q21,
  input  logic [15:0]       q12,
  input  logic [15:0]       q22,
  input  logic [WXW-1:0]    wx0,
  input  logic [WXW-1:0]    wx1,
  input  logic [WYW-1:0]    wy0,
  input  logic [WYW-1:0]    wy1,
  output tbfc_out_t         result
);
  localparam int AW = 17 + WXW + 1;
  localparam int NW = AW + WYW + 1;
  localparam int NN = NW + 1;
  // reciprocal on the top bits of the sum: estimate is low by at most two
  localparam int LSH  = DW - 1;
  localparam int TOPW = NN - LSH;
  localparam longint RECIP = (longint'(1) << NN) / DEN;

  // stage 1: horizontal blends
  logic signed [AW-1:0] row1, row2;
  logic [WYW-1:0] wy0_s1, wy1_s1;
  always_ff @(posedge clk) begin
    if (en) begin
      row1 <= AW'($signed(q11)) * AW'($signed({1'b0, wx0})) +
              AW'($signed(q21)) * AW'($signed({1'b0, wx1}));
      row2 <= AW'($signed(q12)) * AW'($signed({1'b0, wx0})) +
              AW'($signed(q22)) * AW'($signed({1'b0, wx1}));
      wy0_s1 <= wy0;
      wy1_s1 <= wy1;
    end
  end

  // stage 2: vertical blend, offset to nonnegative by 32768*DEN
  logic [NW:0] num;
  always_ff @(posedge clk) begin
    if (en) begin
      num <= (NW+1)'($signed(row1) * $signed({1'b0, wy0_s1}) +
                     $signed(row2) * $signed({1'b0, wy1_s1}) +
                     $signed((NW+1)'(longint'(32768) * DEN)));
    end
  end

  // stage 3: quotient estimate by reciprocal multiply
  logic [TOPW-1:0] q_est;
  logic [NW:0] num_s3;
  always_ff @(posedge clk) begin
    if (en) begin
      q_est  <= TOPW'((64'(num[NW:LSH]) * 64'(RECIP)) >> TOPW);
      num_s3 <= num;
    end
  end

  // stage 4: correct and remove offset, then the color index
  logic [NW:0] rem;
  logic [16:0] q_fix;
  logic signed [16:0] t;
  logic [14:0] n;
  always_comb begin
    rem   = num_s3 - (NW+1)'(64'(q_est) * 64'(DEN));
    q_fix = 17'(q_est) + ((rem >= (NW+1)'(2 * DEN)) ? 17'd2 :
                          (rem >= (NW+1)'(DEN))     ? 17'd1 : 17'd0);
    t     = $signed(q_fix) - 17'sd32768;
    if (t < -17'sd1280) n = '0;
    else if (t > 17'sd19200) n = 15'(COLOR_SPAN);
    else n = 15'(t + 17'sd1280);
  end

  logic [15:0] t_s4;
  logic [14:0] n_s4;
  always_ff @(posedge clk) begin
    if (en) begin
      t_s4 <= t[15:0];
      n_s4 <= n;
    end
  end

  // stage 5: color products; /20480 = /4096 then /5 via reciprocal
  logic [22:0] pr, pg, pb;
  always_comb begin
    pr = 23'(8'd255) * (23'(COLOR_SPAN) - 23'(n_s4));
    pg = 23'(7'd127) * (23'(COLOR_SPAN) - 23'(n_s4));
    pb = 23'(8'd255) * 23'(n_s4);
  end

  function automatic logic [7:0] div_span(input logic [22:0] p);
    logic [10:0] h;
    logic [23:0] m;
    h = p[22:12];
    m = 24'(h) * 24'd6554;
    div_span = 8'(m >> 15);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      result.interp_temp <= t_s4;
      result.red         <= div_span(pr);
      result.green       <= 7'(div_span(pg));
      result.blue        <= div_span(pb);
    end
  end
endmodule

// File: sv/thermal_bilinear_false_color.sv
// Thermal bilinear false color: holds a sensor frame in four parity banks
// and renders one display pixel per clock, unless the output stalls, through
// a pipeline of one memory read, four arithmetic stages and one output
// register. Loads give no result. The pipeline advances whenever the
// output slot is empty or being taken, so throughput is one transaction
// per cycle while the output is not stalled. The banked frame memory read,
// the blends, the reciprocal divide and the color map set the pipeline depth.
module thermal_bilinear_false_color
  import tbfc_pkg::*;
#(
  parameter int IN_WIDTH   = IN_WIDTH_DEF,
  parameter int IN_HEIGHT  = IN_HEIGHT_DEF,
  parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = OUT_HEIGHT_DEF
) (
  input logic clk,
  input logic rst,
  tbfc_if.sink   in_ch,
  tbfc_if.source out_ch
);
  localparam int CW  = $clog2(IN_WIDTH);
  localparam int RW  = $clog2(IN_HEIGHT);
  localparam int WXW = $clog2(OUT_WIDTH + 1);
  localparam int WYW = $clog2(OUT_HEIGHT + 1);
  localparam int DEPTH = 6;
  // exact reciprocals for the axis divides over the product widths
  localparam int SXS = 18 + $clog2(OUT_WIDTH);
  localparam int SYS = 20 + $clog2(OUT_HEIGHT);
  localparam longint RXM = ((longint'(1) << SXS) + OUT_WIDTH - 1) / OUT_WIDTH;
  localparam longint RYM = ((longint'(1) << SYS) + OUT_HEIGHT - 1) / OUT_HEIGHT;

  logic [DEPTH-1:0] vld;
  logic en;
  assign en = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  // axis mapping: small products, constant divides by reciprocal multiply
  logic [7:0] sx;
  logic [8:0] sy;
  logic [17:0] px;
  logic [19:0] py;
  logic [CW-1:0] x1, x2;
  logic [RW-1:0] y1, y2;
  logic [WXW-1:0] fx;
  logic [WYW-1:0] fy;
  logic [WXW-1:0] wx0, wx1;
  logic [WYW-1:0] wy0, wy1;
  logic wr_en;
  logic [CW-1:0] wcol;
  logic [RW-1:0] wrow;

  always_comb begin
    sx = (in_ch.data.screen_x > 8'(OUT_WIDTH - 1)) ? 8'(OUT_WIDTH - 1)
                                                   : in_ch.data.screen_x;
    sy = (in_ch.data.screen_y > 9'(OUT_HEIGHT - 1)) ? 9'(OUT_HEIGHT - 1)
                                                    : in_ch.data.screen_y;
    px = 18'(sx * (IN_WIDTH - 1));
    py = 20'(sy * (IN_HEIGHT - 1));
    x1 = CW'((64'(px) * 64'(RXM)) >> SXS);
    fx = WXW'(32'(px) - 32'(x1) * OUT_WIDTH);
    y1 = RW'((64'(py) * 64'(RYM)) >> SYS);
    fy = WYW'(32'(py) - 32'(y1) * OUT_HEIGHT);
    x2 = (32'(x1) + 1 >= IN_WIDTH) ? x1 : CW'(x1 + 1'b1);
    y2 = (32'(y1) + 1 >= IN_HEIGHT) ? y1 : RW'(y1 + 1'b1);
    wx0 = (x2 == x1) ? WXW'(OUT_WIDTH) : WXW'(OUT_WIDTH) - fx;
    wx1 = (x2 == x1) ? '0 : fx;
    wy0 = (y2 == y1) ? WYW'(OUT_HEIGHT) : WYW'(OUT_HEIGHT) - fy;
    wy1 = (y2 == y1) ? '0 : fy;
    wr_en = acc && in_ch.data.action == ACT_LOAD &&
            32'(in_ch.data.sample_index) < IN_WIDTH * IN_HEIGHT;
    wcol = CW'(32'(in_ch.data.sample_index) % IN_WIDTH);
    wrow = RW'(32'(in_ch.data.sample_index) / IN_WIDTH);
  end

  logic [3:0][15:0] rd;
  tbfc_frame_mem #(.IN_WIDTH(IN_WIDTH), .IN_HEIGHT(IN_HEIGHT)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_col(wcol), .wr_row(wrow),
    .wr_data(in_ch.data.sample_temp), .rd_en(en),
    .col_a(x1), .col_b(x2), .row_a(y1), .row_b(y2), .rd_data(rd)
  );

  // parity selects and weights carried alongside the memory read
  logic x1odd, y1odd;
  logic [WXW-1:0] wx0_r, wx1_r;
  logic [WYW-1:0] wy0_r, wy1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x1odd <= x1[0];
      y1odd <= y1[0];
      wx0_r <= wx0; wx1_r <= wx1;
      wy0_r <= wy0; wy1_r <= wy1;
    end
  end

  // when clamped, x2==x1 and the other bank carries zero weight
  logic [15:0] q11, q21, q12, q22;
  always_comb begin
    q11 = rd[{y1odd, x1odd}];
    q21 = rd[{y1odd, !x1odd}];
    q12 = rd[{!y1odd, x1odd}];
    q22 = rd[{!y1odd, !x1odd}];
  end

  tbfc_out_t res;
  tbfc_interp #(.OUT_WIDTH(OUT_WIDTH), .OUT_HEIGHT(OUT_HEIGHT)) u_interp (
    .clk(clk), .en(en), .q11(q11), .q21(q21), .q12(q12), .q22(q22),
    .wx0(wx0_r), .wx1(wx1_r), .wy0(wy0_r), .wy1(wy1_r), .result(res)
  );

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], acc && in_ch.data.action == ACT_RENDER};
  end

  assign out_ch.valid = vld[DEPTH-1];
  assign out_ch.data  = res;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("pipeline moved while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[DEPTH-1] |-> in_ch.ready) else $error("ready low with empty output");
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && in_ch.data.action == ACT_LOAD) |=> !vld[0])
    else $error("load produced a result");
endmodule
